/* design/v2c_pkg.sv */
package v2c_pkg;

    // Field widths
    localparam int VOLT_W = 24;
    localparam int CAP_W  = 8;
    localparam int MIN_W  = 7;

    // Breakpoint table
    localparam int TABLE_POINTS = 9;
    localparam int LAST_POINT   = TABLE_POINTS - 1;
    localparam int SEGS         = TABLE_POINTS - 1;
    localparam int SEG_W        = $clog2(SEGS);

    // Datapath widths: offset inside a segment, capacity step, scaled offset,
    // reciprocal of the segment span and the quotient left after the shift.
    localparam int POS_W      = 18;
    localparam int DC_W       = 4;
    localparam int X_W        = POS_W + DC_W;
    localparam int RCP_W      = 23;
    localparam int RCP_SHIFT  = 40;
    localparam int Q_W        = 4;
    localparam int PROD_W     = X_W + RCP_W;

    localparam logic [MIN_W-1:0] FALLBACK_MIN_RST = 7'd10;

    localparam logic [VOLT_W-1:0] BP_VOLT [TABLE_POINTS] = '{
        24'd3100000, 24'd3300000, 24'd3500000, 24'd3700000, 24'd3850000,
        24'd4000000, 24'd4150000, 24'd4300000, 24'd4480000
    };

    localparam logic [CAP_W-1:0] BP_CAP [TABLE_POINTS] = '{
        8'd0, 8'd10, 8'd25, 8'd40, 8'd55, 8'd70, 8'd85, 8'd95, 8'd100
    };

    // Per-segment view of the table: low voltage, low capacity, capacity step
    localparam logic [VOLT_W-1:0] SEG_LO_VOLT [SEGS] = '{
        24'd3100000, 24'd3300000, 24'd3500000, 24'd3700000,
        24'd3850000, 24'd4000000, 24'd4150000, 24'd4300000
    };

    localparam logic [CAP_W-1:0] SEG_C0 [SEGS] = '{
        8'd0, 8'd10, 8'd25, 8'd40, 8'd55, 8'd70, 8'd85, 8'd95
    };

    localparam logic [DC_W-1:0] SEG_DC [SEGS] = '{
        4'd10, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd10, 4'd5
    };

    // ceil(2^RCP_SHIFT / span); exact floor division for any offset product
    // below 2^X_W with spans below 2^POS_W.
    localparam logic [RCP_W-1:0] SEG_RCP [SEGS] = '{
        23'd5497559, 23'd5497559, 23'd5497559, 23'd7330078,
        23'd7330078, 23'd7330078, 23'd7330078, 23'd6108398
    };

    typedef struct packed {
        logic [VOLT_W-1:0] batt_uv;
        logic              read_ok;
        logic [CAP_W-1:0]  original_capacity;
    } t_in_beat;

    // After the segment search
    typedef struct packed {
        logic              scale;
        logic [SEG_W-1:0]  seg;
        logic [VOLT_W-1:0] batt_uv;
        logic [CAP_W-1:0]  base;
    } t_loc;

    // After the offset subtraction and table lookup
    typedef struct packed {
        logic [CAP_W-1:0] base;
        logic [POS_W-1:0] pos;
        logic [DC_W-1:0]  dc;
        logic [RCP_W-1:0] rcp;
    } t_ofs;

    // After the step multiply
    typedef struct packed {
        logic [CAP_W-1:0] base;
        logic [X_W-1:0]   x;
        logic [RCP_W-1:0] rcp;
    } t_mul;

    // After the reciprocal multiply
    typedef struct packed {
        logic [CAP_W-1:0] base;
        logic [Q_W-1:0]   q;
    } t_quo;

endpackage

/* design/v2c_if.sv */
interface v2c_in_if;
    logic                          valid;
    logic                          ready;
    logic [v2c_pkg::VOLT_W-1:0]    batt_uv;
    logic                          read_ok;
    logic [v2c_pkg::CAP_W-1:0]     original_capacity;

    modport source (output valid, batt_uv, read_ok, original_capacity, input ready);
    modport sink   (input valid, batt_uv, read_ok, original_capacity, output ready);
endinterface

interface v2c_out_if;
    logic                          valid;
    logic                          ready;
    logic [v2c_pkg::CAP_W-1:0]     charge_pct;

    modport source (output valid, charge_pct, input ready);
    modport sink   (input valid, charge_pct, output ready);
endinterface

/* design/voltage_to_capacity_interpolator_top.sv */
// Throughput: one beat per cycle while the output takes beats; five register
// stages (segment search, offset lookup, step multiply, reciprocal multiply,
// output add) each hold one.
// A stalled output holds only the stages that are full; bubbles still close up.
// Reset (synchronous, active low) empties every stage and sets the fallback
// minimum capacity to 10.
module voltage_to_capacity_interpolator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [v2c_pkg::MIN_W-1:0]   i_cfg_wdata,
    v2c_in_if.sink                      i_in,
    v2c_out_if.source                   o_out
);

    logic [v2c_pkg::MIN_W-1:0] r_fb_min;

    v2c_pkg::t_in_beat in_beat;
    v2c_pkg::t_ofs     ofs_beat;
    logic              ofs_valid;
    logic              ofs_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_min <= v2c_pkg::FALLBACK_MIN_RST;
        end else if (i_cfg_we) begin
            r_fb_min <= i_cfg_wdata;
        end
    end

    always_comb begin
        in_beat.batt_uv           = i_in.batt_uv;
        in_beat.read_ok           = i_in.read_ok;
        in_beat.original_capacity = i_in.original_capacity;
    end

    v2c_locate u_locate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fb_min (r_fb_min),
        .i_valid  (i_in.valid),
        .i_beat   (in_beat),
        .o_ready  (i_in.ready),
        .o_valid  (ofs_valid),
        .o_beat   (ofs_beat),
        .i_ready  (ofs_ready)
    );

    v2c_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (ofs_valid),
        .i_beat         (ofs_beat),
        .o_ready        (ofs_ready),
        .o_valid        (o_out.valid),
        .o_charge_pct   (o_out.charge_pct),
        .i_ready        (o_out.ready)
    );

endmodule

/* design/v2c_locate.sv */
module v2c_locate (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [v2c_pkg::MIN_W-1:0]   i_fb_min,
    input  logic                        i_valid,
    input  v2c_pkg::t_in_beat           i_beat,
    output logic                        o_ready,
    output logic                        o_valid,
    output v2c_pkg::t_ofs               o_beat,
    input  logic                        i_ready
);

    logic              r_a_valid;
    v2c_pkg::t_loc     r_a;
    v2c_pkg::t_loc     n_a;
    logic              a_ready;

    logic              r_b_valid;
    v2c_pkg::t_ofs     r_b;
    v2c_pkg::t_ofs     n_b;
    logic              b_ready;

    logic              usable;
    logic              above_lo;
    logic              below_hi;
    logic [v2c_pkg::CAP_W-1:0] fb_cap;
    logic [v2c_pkg::VOLT_W-1:0] diff;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Stage A: compare against every breakpoint, pick the segment, the clamp or the fallback level
    always_comb begin
        usable   = i_beat.read_ok && (i_beat.batt_uv != '0);
        above_lo = i_beat.batt_uv > v2c_pkg::BP_VOLT[0];
        below_hi = i_beat.batt_uv < v2c_pkg::BP_VOLT[v2c_pkg::LAST_POINT];
        fb_cap   = (i_beat.original_capacity < {1'b0, i_fb_min}) ?
                   {1'b0, i_fb_min} : i_beat.original_capacity;

        n_a.batt_uv = i_beat.batt_uv;
        n_a.scale   = usable && above_lo && below_hi;
        n_a.seg     = '0;
        for (int i = 1; i < v2c_pkg::LAST_POINT; i++) begin
            n_a.seg = n_a.seg +
                      v2c_pkg::SEG_W'(i_beat.batt_uv >= v2c_pkg::BP_VOLT[i]);
        end

        priority if (!usable) begin
            n_a.base = fb_cap;
        end else if (!above_lo) begin
            n_a.base = v2c_pkg::BP_CAP[0];
        end else if (!below_hi) begin
            n_a.base = v2c_pkg::BP_CAP[v2c_pkg::LAST_POINT];
        end else begin
            n_a.base = '0;
        end
    end

    // Stage B: offset inside the segment and the segment constants, or the stage A base
    always_comb begin
        diff = r_a.batt_uv - v2c_pkg::SEG_LO_VOLT[r_a.seg];
        if (r_a.scale) begin
            n_b.base = v2c_pkg::SEG_C0[r_a.seg];
            n_b.pos  = diff[v2c_pkg::POS_W-1:0];
            n_b.dc   = v2c_pkg::SEG_DC[r_a.seg];
            n_b.rcp  = v2c_pkg::SEG_RCP[r_a.seg];
        end else begin
            n_b.base = r_a.base;
            n_b.pos  = '0;
            n_b.dc   = '0;
            n_b.rcp  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a <= n_a;
        end
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_beat  = r_b;

`ifndef ASSERT_OFF
    a_scale_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a.scale |->
            (r_a.batt_uv > v2c_pkg::BP_VOLT[0]) &&
            (r_a.batt_uv < v2c_pkg::BP_VOLT[v2c_pkg::LAST_POINT]))
        else $error("segment chosen for a clamped voltage");

    a_stage_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !b_ready |=> r_a_valid && $stable(r_a))
        else $error("stage A beat lost under stall");

    a_pos_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a.scale && b_ready |=>
            r_b_valid && (r_b.dc != '0) && (r_b.rcp != '0))
        else $error("interpolated beat lost its segment constants");
`endif

endmodule

/* design/v2c_scale.sv */
module v2c_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  v2c_pkg::t_ofs               i_beat,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [v2c_pkg::CAP_W-1:0]   o_charge_pct,
    input  logic                        i_ready
);

    logic              r_c_valid;
    v2c_pkg::t_mul     r_c;
    v2c_pkg::t_mul     n_c;
    logic              c_ready;

    logic              r_d_valid;
    v2c_pkg::t_quo     r_d;
    v2c_pkg::t_quo     n_d;
    logic              d_ready;

    logic                        r_e_valid;
    logic [v2c_pkg::CAP_W-1:0]   r_e_cap;
    logic [v2c_pkg::CAP_W-1:0]   n_e_cap;
    logic                        e_ready;

    logic [v2c_pkg::PROD_W-1:0]  prod;

    assign e_ready = !r_e_valid || i_ready;
    assign d_ready = !r_d_valid || e_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    // Stage C: capacity step times offset
    always_comb begin
        n_c.base = i_beat.base;
        n_c.rcp  = i_beat.rcp;
        n_c.x    = v2c_pkg::X_W'(i_beat.pos) * v2c_pkg::X_W'(i_beat.dc);
    end

    // Stage D: divide by the span through its reciprocal
    always_comb begin
        prod     = v2c_pkg::PROD_W'(r_c.x) * v2c_pkg::PROD_W'(r_c.rcp);
        n_d.base = r_c.base;
        n_d.q    = prod[v2c_pkg::RCP_SHIFT +: v2c_pkg::Q_W];
    end

    // Stage E: add the segment floor; output register
    assign n_e_cap = r_d.base + v2c_pkg::CAP_W'(r_d.q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_valid <= i_valid;
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
            end
            if (e_ready) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && i_valid) begin
            r_c <= n_c;
        end
        if (d_ready && r_c_valid) begin
            r_d <= n_d;
        end
        if (e_ready && r_d_valid) begin
            r_e_cap <= n_e_cap;
        end
    end

    assign o_valid      = r_e_valid;
    assign o_charge_pct = r_e_cap;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && (r_d.q != '0) |-> ({1'b0, r_d.base} + 9'(r_d.q)) <= 9'd100)
        else $error("interpolated capacity above full scale");

    a_stage_c_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !d_ready |=> r_c_valid && $stable(r_c))
        else $error("stage C beat lost under stall");

    a_stage_d_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && !e_ready |=> r_d_valid && $stable(r_d))
        else $error("stage D beat lost under stall");
`endif

endmodule

/* dv/v2c_checker.sv */
`timescale 1ns / 100ps

module v2c_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [v2c_pkg::MIN_W-1:0] i_cfg_wdata,
    v2c_in_if                         i_in_mon,
    v2c_out_if                        i_out_mon,
    output int                        o_mismatches,
    output int                        o_pending
);

    logic [v2c_pkg::MIN_W-1:0] min_cap;
    logic [v2c_pkg::CAP_W-1:0] soc_due [$];
    logic [v2c_pkg::CAP_W-1:0] soc_want;
    int                        n_bad = 0;

    // Charge level for one reading: table interpolation, or the reported level
    // raised to the floor when there is no usable voltage.
    function automatic logic [v2c_pkg::CAP_W-1:0] soc_from_reading(
        input logic [v2c_pkg::VOLT_W-1:0] volt,
        input logic                       ok,
        input logic [v2c_pkg::CAP_W-1:0]  orig,
        input logic [v2c_pkg::MIN_W-1:0]  floor_cap
    );
        longint unsigned span;
        longint unsigned ofs;
        longint unsigned c0;
        longint unsigned c1;
        if (!ok || volt == '0)
            return (orig < {1'b0, floor_cap}) ? {1'b0, floor_cap} : orig;
        if (volt <= v2c_pkg::BP_VOLT[0])
            return v2c_pkg::BP_CAP[0];
        if (volt >= v2c_pkg::BP_VOLT[v2c_pkg::LAST_POINT])
            return v2c_pkg::BP_CAP[v2c_pkg::LAST_POINT];
        for (int k = 0; k < v2c_pkg::LAST_POINT; k++) begin
            if (volt < v2c_pkg::BP_VOLT[k+1]) begin
                span = v2c_pkg::BP_VOLT[k+1] - v2c_pkg::BP_VOLT[k];
                ofs  = volt - v2c_pkg::BP_VOLT[k];
                c0   = v2c_pkg::BP_CAP[k];
                c1   = v2c_pkg::BP_CAP[k+1];
                if (span == 0)
                    return c0[v2c_pkg::CAP_W-1:0];
                if (c1 >= c0)
                    return v2c_pkg::CAP_W'(c0 + (c1 - c0) * ofs / span);
                return v2c_pkg::CAP_W'(c0 - (c0 - c1) * ofs / span);
            end
        end
        return v2c_pkg::BP_CAP[0];
    endfunction

    // Retire the output beat before queueing the input beat of the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_cap = v2c_pkg::FALLBACK_MIN_RST;
            soc_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (soc_due.size() == 0) begin
                    $display("%0t: charge_pct expected none, actual %0d", $time,
                             i_out_mon.charge_pct);
                    n_bad++;
                end else begin
                    soc_want = soc_due.pop_front();
                    if (i_out_mon.charge_pct !== soc_want) begin
                        $display("%0t: charge_pct expected %0d, actual %0d", $time,
                                 soc_want, i_out_mon.charge_pct);
                        n_bad++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                soc_due.push_back(soc_from_reading(i_in_mon.batt_uv, i_in_mon.read_ok,
                                                   i_in_mon.original_capacity, min_cap));
            if (i_cfg_we)
                min_cap = i_cfg_wdata;
        end
        o_mismatches <= n_bad;
        o_pending    <= soc_due.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASE_BEATS = 275;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [v2c_pkg::MIN_W-1:0] cfg_wdata;
    logic                      steady = 1'b0;
    int                        mismatches;
    int                        pending;
    int                        cycles = 0;

    v2c_in_if  in_ch ();
    v2c_out_if out_ch ();

    voltage_to_capacity_interpolator_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    v2c_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= i_rst_n && (steady || $urandom_range(99) >= 19);
    end

    task automatic send_reading(input logic [v2c_pkg::VOLT_W-1:0] volt, input logic ok,
                                input logic [v2c_pkg::CAP_W-1:0] orig);
        while (!steady && $urandom_range(99) < 19) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.batt_uv           <= volt;
        in_ch.read_ok           <= ok;
        in_ch.original_capacity <= orig;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid, wait out every pending result and the pipeline tail.
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_cap(input logic [v2c_pkg::MIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_readings(input int count);
        logic [v2c_pkg::VOLT_W-1:0] volt;
        int                         pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                volt = v2c_pkg::VOLT_W'($urandom_range(4600000, 3000000));
            else if (pick < 80)
                volt = v2c_pkg::BP_VOLT[$urandom_range(v2c_pkg::LAST_POINT)] +
                       v2c_pkg::VOLT_W'($urandom_range(4)) - v2c_pkg::VOLT_W'(2);
            else if (pick < 93)
                volt = v2c_pkg::VOLT_W'($urandom);
            else if (pick < 97)
                volt = v2c_pkg::VOLT_W'($urandom_range(3));
            else
                volt = '0;
            send_reading(volt, $urandom_range(99) < 85,
                         v2c_pkg::CAP_W'($urandom_range(255)));
        end
    endtask

    initial begin
        i_rst_n                  <= 1'b0;
        cfg_we                   <= 1'b0;
        cfg_wdata                <= '0;
        in_ch.valid              <= 1'b0;
        in_ch.batt_uv            <= '0;
        in_ch.read_ok            <= 1'b0;
        in_ch.original_capacity  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Table edges under the reset floor: each breakpoint and one below it.
        for (int k = 0; k <= v2c_pkg::LAST_POINT; k++) begin
            send_reading(v2c_pkg::BP_VOLT[k], 1'b1, 8'd50);
            send_reading(v2c_pkg::BP_VOLT[k] - v2c_pkg::VOLT_W'(1), 1'b1, 8'd50);
        end
        send_reading('0, 1'b1, 8'd3);
        send_reading('0, 1'b0, 8'd255);
        send_reading(24'd1, 1'b1, 8'd200);
        send_reading('1, 1'b1, 8'd0);
        send_reading('1, 1'b0, 8'd0);
        send_reading(24'd3700000, 1'b0, 8'd9);
        drain_pipe();

        write_min_cap(7'd0);
        send_random_readings(PHASE_BEATS);
        drain_pipe();

        // Hold both sides busy for a whole phase.
        write_min_cap(7'd127);
        steady = 1'b1;
        send_random_readings(PHASE_BEATS);
        drain_pipe();
        steady = 1'b0;

        write_min_cap(7'd100);
        send_random_readings(PHASE_BEATS);
        drain_pipe();

        write_min_cap(v2c_pkg::MIN_W'($urandom_range(127)));
        send_random_readings(PHASE_BEATS);
        drain_pipe();

        write_min_cap(v2c_pkg::FALLBACK_MIN_RST);
        send_random_readings(PHASE_BEATS);
        drain_pipe();

        if (mismatches == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
